// ----- src/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpp_pkg: shared types and constants for the tagged payload parser
// Transaction payload structs, result and status codes, record types,
// parse phases and the sizing constants of the design.
// ----------------------------------------------------------------------------
`default_nettype none

package tpp_pkg;

  // Sizing
  localparam int MAX_ENTRIES = 16;
  localparam int MAX_CONTENT = 1024;
  localparam int MAX_RES     = 3;
  localparam int FIFO_DEPTH  = 8;

  localparam int ED_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CL_W  = $clog2(MAX_CONTENT + 2);
  localparam int RES_W = $clog2(MAX_RES + 1);

  // Header and separator bytes
  localparam logic [7:0] HDR_LEAD  = 8'h01;
  localparam logic [7:0] HDR_SEL_A = 8'h20;
  localparam logic [7:0] HDR_SEL_B = 8'h10;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  // Result kinds
  localparam logic [1:0] RK_CONTENT = 2'd0;
  localparam logic [1:0] RK_ENTRY   = 2'd1;
  localparam logic [1:0] RK_RECORD  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  // Record types
  localparam logic [3:0] REC_UNKNOWN = 4'd0;
  localparam logic [3:0] REC_TEXT    = 4'd1;
  localparam logic [3:0] REC_CARD    = 4'd2;
  localparam logic [3:0] REC_SMS     = 4'd3;
  localparam logic [3:0] REC_MAIL    = 4'd4;
  localparam logic [3:0] REC_URL     = 4'd5;
  localparam logic [3:0] REC_DTEXT   = 4'd6;
  localparam logic [3:0] REC_AD      = 4'd7;
  localparam logic [3:0] REC_BLOG    = 4'd8;
  localparam logic [3:0] REC_GIS     = 4'd9;
  localparam logic [3:0] REC_ENC     = 4'd10;
  localparam logic [3:0] REC_BAR     = 4'd11;
  localparam logic [3:0] REC_PHONE   = 4'd12;

  // Plain text content carries entry code one
  localparam logic [4:0] EK_TEXT = 5'd1;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_TEXT,
    PH_TYPE,
    PH_ETAG,
    PH_BODY,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] record_type;
    logic [4:0] entry_type;
    logic [7:0] content_byte;
    logic [3:0] entry_index;
    logic [4:0] entry_count;
    logic [1:0] status;
    logic       last_result;
  } out_item_t;

  // Results of one item, handed to the result queue
  typedef struct packed {
    logic [RES_W-1:0]            count;
    out_item_t [MAX_RES-1:0]     slot;
  } push_t;

endpackage

`default_nettype wire

// ----- src/tagged_payload_parser_core.sv -----
// Path: an accepted byte is held in the input register, its results are written
//   into the result queue storage, and the queue drives the output.
// Throughput: one byte per cycle while each byte yields at most one result, the
//   queue has room and the one-result-per-cycle output is not stalled.
// Reset: rst_ni low clears the parse state, the input register and the
//   result queue; the parser waits for the first header byte.
// ----------------------------------------------------------------------------
// tagged_payload_parser_core: tagged payload parser top level
// Input register, per-byte step logic and result queue for a byte stream of
// decoded 2-D code payloads.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_payload_parser_core
  import tpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  logic     in_valid_q, in_valid_d;
  in_item_t in_q;
  logic     room;
  logic     advance;
  push_t    push;

  // Registered byte moves on when the queue has room for its results
  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) in_valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  tpp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .push_o    (push)
  );

  tpp_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// ----- src/tpp_step.sv -----
// ----------------------------------------------------------------------------
// tpp_step: parse state and per-byte step logic
// Holds the parser state and turns one registered payload byte into up to
// three result items, updating the state when the item advances.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_step
  import tpp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  phase_e           ph_q, ph_d;
  logic [7:0]       held_q, held_d;
  logic [31:0]      tag_q, tag_d;
  logic [3:0]       rk_q, rk_d;
  logic [4:0]       ek_q, ek_d;
  logic [ED_W-1:0]  ed_q, ed_d;
  logic [CL_W-1:0]  cl_q, cl_d;
  logic             as_q, as_d;

  out_item_t [MAX_RES-1:0] slot_d;
  logic [RES_W-1:0]        n_d;
  logic                    held_go, text_go;
  logic [7:0]              b;
  logic                    last;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  // Type tag to record type
  function automatic logic [3:0] type_lookup(input logic [31:0] tag);
    logic [3:0] k;
    unique case (tag)
      32'h0000_0000:     k = REC_TEXT;
      "CARD":            k = REC_CARD;
      {8'h00, "SMS"}:    k = REC_SMS;
      "MAIL":            k = REC_MAIL;
      "SITE":            k = REC_URL;
      "DTXT":            k = REC_DTEXT;
      {16'h0000, "AD"}:  k = REC_AD;
      "BLOG":            k = REC_BLOG;
      {8'h00, "GIS"}:    k = REC_GIS;
      {8'h00, "ENC"}:    k = REC_ENC;
      "MARK":            k = REC_URL;
      {16'h0000, "BM"}:  k = REC_URL;
      "LBAR":            k = REC_BAR;
      "HONE":            k = REC_PHONE;
      default:           k = REC_UNKNOWN;
    endcase
    return k;
  endfunction

  // Entry tag to entry code, per record type; zero when unmatched
  function automatic logic [4:0] entry_lookup(input logic [3:0] kind,
                                              input logic [31:0] tag);
    logic [4:0] c;
    c = 5'd0;
    unique case (kind)
      REC_CARD: begin
        unique case (tag)
          {24'h0, "N"}:   c = 5'd1;
          {8'h0, "TIL"}:  c = 5'd2;
          {8'h0, "DIV"}:  c = 5'd3;
          {8'h0, "COR"}:  c = 5'd4;
          {8'h0, "ADR"}:  c = 5'd5;
          {8'h0, "ZIP"}:  c = 5'd6;
          {24'h0, "M"}:   c = 5'd7;
          {8'h0, "TEL"}:  c = 5'd8;
          {8'h0, "FAX"}:  c = 5'd9;
          {16'h0, "EM"}:  c = 5'd10;
          {16'h0, "IM"}:  c = 5'd11;
          default:        c = 5'd0;
        endcase
      end
      REC_SMS: begin
        unique case (tag)
          {16'h0, "SM"}:  c = 5'd1;
          {8'h0, "TXT"}:  c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_MAIL: begin
        unique case (tag)
          {16'h0, "TO"}:  c = 5'd1;
          {8'h0, "SUB"}:  c = 5'd2;
          {8'h0, "TXT"}:  c = 5'd3;
          default:        c = 5'd0;
        endcase
      end
      REC_URL: begin
        unique case (tag)
          "TITL":         c = 5'd1;
          {8'h0, "URL"}:  c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_DTEXT: begin
        unique case (tag)
          {8'h0, "SUB"}:  c = 5'd1;
          {8'h0, "TXT"}:  c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_AD: begin
        unique case (tag)
          {8'h0, "SUB"}:  c = 5'd1;
          {8'h0, "URL"}:  c = 5'd2;
          {16'h0, "CT"}:  c = 5'd3;
          default:        c = 5'd0;
        endcase
      end
      REC_BLOG: begin
        unique case (tag)
          {8'h0, "SUB"}:  c = 5'd1;
          {8'h0, "URL"}:  c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_GIS: begin
        if (tag == {8'h0, "URL"}) c = 5'd1;
      end
      REC_ENC: begin
        unique case (tag)
          {8'h0, "TXT"}:  c = 5'd1;
          {8'h0, "PWD"}:  c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_BAR: begin
        unique case (tag)
          {24'h0, "T"}:   c = 5'd1;
          "CODE":         c = 5'd2;
          default:        c = 5'd0;
        endcase
      end
      REC_PHONE: begin
        unique case (tag)
          {8'h0, "SUB"}:  c = 5'd1;
          {8'h0, "TEL"}:  c = 5'd2;
          {24'h0, "M"}:   c = 5'd3;
          default:        c = 5'd0;
        endcase
      end
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // Build one result, saturating index and count
  function automatic out_item_t mk_res(input logic [1:0] kind, input logic [3:0] rt,
                                       input logic [4:0] et, input logic [7:0] by,
                                       input logic [1:0] st, input logic [7:0] idx,
                                       input logic [7:0] cnt);
    out_item_t r;
    r.result_kind  = kind;
    r.record_type  = rt;
    r.entry_type   = et;
    r.content_byte = by;
    r.entry_index  = (idx > 8'd15) ? 4'd15 : idx[3:0];
    r.entry_count  = (cnt > 8'd31) ? 5'd31 : cnt[4:0];
    r.status       = st;
    r.last_result  = 1'b0;
    return r;
  endfunction

  // Step logic: next state and results of the current item
  always_comb begin
    ph_d    = ph_q;
    held_d  = held_q;
    tag_d   = tag_q;
    rk_d    = rk_q;
    ek_d    = ek_q;
    ed_d    = ed_q;
    cl_d    = cl_q;
    as_d    = as_q;
    slot_d  = '0;
    n_d     = '0;
    held_go = 1'b0;
    text_go = 1'b0;

    if (advance_i) begin
      unique case (ph_q)
        PH_HDR0: begin
          held_d = b;
          tag_d  = '0;
          rk_d   = REC_UNKNOWN;
          ek_d   = '0;
          ed_d   = '0;
          cl_d   = '0;
          as_d   = 1'b0;
          if (b == HDR_LEAD && !last) begin
            ph_d = PH_HDR1;
          end else begin
            rk_d    = REC_TEXT;
            text_go = 1'b1;
          end
        end
        PH_HDR1: begin
          if (b == HDR_SEL_A || b == HDR_SEL_B) begin
            tag_d = '0;
            ph_d  = PH_TYPE;
            if (last) begin
              rk_d = type_lookup('0);
              slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0, ST_OK,
                                   8'(ed_d), 8'(ed_d));
              n_d  = n_d + 1'b1;
              ph_d = PH_HDR0;
            end
          end else begin
            rk_d    = REC_TEXT;
            held_go = 1'b1;
            text_go = 1'b1;
          end
        end
        PH_TEXT: text_go = 1'b1;
        PH_TYPE: begin
          if (b != CH_COLON) tag_d = {tag_q[23:0], b};
          if (b == CH_COLON || last) begin
            rk_d = type_lookup(tag_d);
            if (rk_d == REC_UNKNOWN || rk_d == REC_TEXT || last) begin
              slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0,
                                   (rk_d == REC_UNKNOWN) ? ST_UNKNOWN : ST_OK,
                                   8'(ed_d), 8'(ed_d));
              n_d  = n_d + 1'b1;
              ph_d = last ? PH_HDR0 : PH_SKIP;
            end else begin
              tag_d = '0;
              as_d  = 1'b0;
              ph_d  = PH_ETAG;
            end
          end
        end
        PH_ETAG: begin
          as_d = 1'b0;
          if (as_q && b == CH_SEMI) begin
            // double separator closes the record
            slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0, ST_OK,
                                 8'(ed_d), 8'(ed_d));
            n_d  = n_d + 1'b1;
            ph_d = last ? PH_HDR0 : PH_SKIP;
          end else begin
            if (b != CH_COLON) tag_d = {tag_q[23:0], b};
            if (last) begin
              slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0, ST_OK,
                                   8'(ed_d), 8'(ed_d));
              n_d  = n_d + 1'b1;
              ph_d = PH_HDR0;
            end else if (b == CH_COLON) begin
              ek_d = entry_lookup(rk_q, tag_d);
              cl_d = '0;
              ph_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          // content byte
          if (b != CH_SEMI) begin
            if (cl_d < CL_W'(MAX_CONTENT)) begin
              cl_d = cl_d + 1'b1;
              if (ed_d < ED_W'(MAX_ENTRIES)) begin
                slot_d[n_d] = mk_res(RK_CONTENT, rk_d, ek_d, b, ST_OK,
                                     8'(ed_d), 8'(ed_d));
                n_d = n_d + 1'b1;
              end
            end else begin
              cl_d = CL_W'(MAX_CONTENT + 1);
            end
          end
          if (b == CH_SEMI || last) begin
            // close the entry; empty entries are dropped
            if (cl_d != '0) begin
              if (ed_d >= ED_W'(MAX_ENTRIES)) begin
                slot_d[n_d] = mk_res(RK_ENTRY, rk_d, ek_d, 8'd0, ST_TOO_MANY,
                                     8'(ed_d), 8'(ed_d));
                n_d = n_d + 1'b1;
              end else begin
                slot_d[n_d] = mk_res(RK_ENTRY, rk_d, ek_d, 8'd0,
                                     (cl_d > CL_W'(MAX_CONTENT)) ? ST_OVERFLOW : ST_OK,
                                     8'(ed_d), 8'(ed_d) + 8'd1);
                n_d  = n_d + 1'b1;
                ed_d = ed_d + 1'b1;
              end
            end
            if (last) begin
              slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0, ST_OK,
                                   8'(ed_d), 8'(ed_d));
              n_d  = n_d + 1'b1;
              ph_d = PH_HDR0;
            end else begin
              as_d  = 1'b1;
              tag_d = '0;
              ph_d  = PH_ETAG;
            end
          end
        end
        PH_SKIP: begin
          if (last) ph_d = PH_HDR0;
        end
        default: ph_d = PH_HDR0;
      endcase

      // Held lead byte of an unmatched header goes out as text
      if (held_go) begin
        if (cl_d < CL_W'(MAX_CONTENT)) begin
          cl_d = cl_d + 1'b1;
          slot_d[n_d] = mk_res(RK_CONTENT, rk_d, EK_TEXT, held_q, ST_OK,
                               8'(ed_d), 8'(ed_d));
          n_d = n_d + 1'b1;
        end else begin
          cl_d = CL_W'(MAX_CONTENT + 1);
        end
      end

      // Plain text byte; zero byte or last byte closes the record
      if (text_go) begin
        if (b != 8'd0) begin
          if (cl_d < CL_W'(MAX_CONTENT)) begin
            cl_d = cl_d + 1'b1;
            slot_d[n_d] = mk_res(RK_CONTENT, rk_d, EK_TEXT, b, ST_OK,
                                 8'(ed_d), 8'(ed_d));
            n_d = n_d + 1'b1;
          end else begin
            cl_d = CL_W'(MAX_CONTENT + 1);
          end
        end
        if (b == 8'd0 || last) begin
          ed_d = ED_W'(1);
          slot_d[n_d] = mk_res(RK_RECORD, rk_d, 5'd0, 8'd0,
                               (cl_d > CL_W'(MAX_CONTENT)) ? ST_OVERFLOW : ST_OK,
                               8'(ed_d), 8'(ed_d));
          n_d  = n_d + 1'b1;
          ph_d = last ? PH_HDR0 : PH_SKIP;
        end else begin
          ph_d = PH_TEXT;
        end
      end

      // Mark the final result of this item
      if (n_d != '0) slot_d[n_d - 1'b1].last_result = 1'b1;
    end
  end

  assign push_o.count = n_d;
  assign push_o.slot  = slot_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR0;
      held_q <= '0;
      tag_q  <= '0;
      rk_q   <= REC_UNKNOWN;
      ek_q   <= '0;
      ed_q   <= '0;
      cl_q   <= '0;
      as_q   <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      held_q <= held_d;
      tag_q  <= tag_d;
      rk_q   <= rk_d;
      ek_q   <= ek_d;
      ed_q   <= ed_d;
      cl_q   <= cl_d;
      as_q   <= as_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/tpp_res_fifo.sv -----
// ----------------------------------------------------------------------------
// tpp_res_fifo: result queue
// Takes up to three results per cycle from the step logic and hands them
// out one transaction per cycle on the output channel, unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_res_fifo
  import tpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for a full burst of results
  assign room_o      = (cnt_q <= CNT_W'(FIFO_DEPTH - MAX_RES));

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_W'(i) < push_i.count) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= push_i.slot[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tpp_checker.sv -----
// ----------------------------------------------------------------------------
// tpp_checker: port-level checks for the tagged payload parser
// Watches the output channel and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_checker
  import tpp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input out_item_t out_data_o,
  input logic      out_stall_i
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // Input only stalls while results are waiting in the queue
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result queue");

  // A record close is always the final result of its byte
  a_rec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == RK_RECORD |-> out_data_o.last_result)
    else $error("record complete not marked last");

  // Non-content results carry no byte
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind != RK_CONTENT |->
      out_data_o.content_byte == 8'd0)
    else $error("content byte on a non-content result");

  // Record close carries entry code zero
  a_rec_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == RK_RECORD |->
      out_data_o.entry_type == 5'd0)
    else $error("record complete with nonzero entry code");

endmodule

bind tagged_payload_parser_core tpp_checker u_tpp_checker (.*);

`default_nettype wire
